FILE: hw/rtl/rfd_pkg.sv
// Package for the run-length frame decoder.
// Holds the field widths, the decoder phase type and the packet constants.
// No dependencies.
`default_nettype none

package rfd_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int LEN_WIDTH   = 8;
   localparam int SIZE_WIDTH  = 33;
   localparam int HDR_WIDTH   = 2;

   // Count bytes above this value start a run packet.
   localparam logic [BYTE_WIDTH-1:0] RUN_THRESHOLD = 8'h7f;
   // Last index of a four-byte header field.
   localparam logic [HDR_WIDTH-1:0]  HDR_LAST      = 2'd3;
   // A run of count byte c repeats its data byte RUN_BASE - c times.
   localparam logic [BYTE_WIDTH:0]   RUN_BASE      = 9'd257;

   localparam logic                  STATUS_DATA   = 1'b0;
   localparam logic                  STATUS_BAD_CMD = 1'b1;

   typedef enum logic [2:0] {
      PH_WAIT_CMD = 3'd0,
      PH_SKIP     = 3'd1,
      PH_SIZE     = 3'd2,
      PH_COUNT    = 3'd3,
      PH_RUN_DATA = 3'd4,
      PH_LITERAL  = 3'd5
   } phase_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rfd_req_if.sv
// Input channel of the run-length frame decoder: one compressed byte per transaction.
// Depends on rfd_pkg for the field width.
`default_nettype none

interface rfd_req_if;
   logic                           valid;
   logic                           ready;
   logic [rfd_pkg::BYTE_WIDTH-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rfd_rsp_if.sv
// Result channel of the run-length frame decoder: one decoded byte, run or error report per transaction.
// Depends on rfd_pkg for the field widths.
`default_nettype none

interface rfd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rfd_pkg::BYTE_WIDTH-1:0] out_byte;
   logic [rfd_pkg::LEN_WIDTH-1:0]  repeat_len;
   logic                           frame_end;
   logic                           status;

   modport source (output valid, output out_byte, output repeat_len,
                   output frame_end, output status, input ready);
   modport sink   (input valid, input out_byte, input repeat_len,
                   input frame_end, input status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rle_frame_decoder_unit.sv
// Run-length frame decoder, top level. Depends on rfd_pkg, rfd_req_if and rfd_rsp_if.
// A byte that yields a result presents it in the cycle after its transaction.
// Throughput: one byte per cycle; the only stall is a result register that is full
// and not being taken. Reset (synchronous, active high) returns to waiting for a
// command byte, clears all counters, empties the result register and sets the
// frame command code to zero.
`default_nettype none

module rle_frame_decoder_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rfd_req_if.sink                             req_channel,
   rfd_rsp_if.source                           rsp_channel,
   input  wire logic                           csr_write_enable,
   input  wire logic [rfd_pkg::BYTE_WIDTH-1:0] csr_write_data
);

   // Decoder state. The phase walks command, skipped packed size, unpacked
   // size, then alternates between count bytes and packet bodies.
   rfd_pkg::phase_type                 phase_ff, phase_in;
   logic [rfd_pkg::HDR_WIDTH-1:0]      header_count_ff, header_count_in;
   logic signed [rfd_pkg::SIZE_WIDTH-1:0] remaining_ff, remaining_in;
   logic [rfd_pkg::LEN_WIDTH-1:0]      literal_left_ff, literal_left_in;
   logic [rfd_pkg::LEN_WIDTH-1:0]      run_len_ff, run_len_in;
   logic [rfd_pkg::BYTE_WIDTH-1:0]     command_code_ff;

   // Result register. It is the skid stage between the two channels: a new
   // byte is taken whenever the register is empty or its contents leave now.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rfd_pkg::BYTE_WIDTH-1:0]     out_byte_ff, out_byte_in;
   logic [rfd_pkg::LEN_WIDTH-1:0]      repeat_len_ff, repeat_len_in;
   logic                               frame_end_ff, frame_end_in;
   logic                               status_ff, status_in;

   logic                               accept;
   logic                               emit;
   logic [rfd_pkg::BYTE_WIDTH-1:0]     data;
   logic                               size_done;
   logic [rfd_pkg::LEN_WIDTH-1:0]      literal_dec;

   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign accept            = req_channel.valid && req_channel.ready;
   assign data              = req_channel.in_byte;

   // The size is signed; the frame is over once it reaches zero or goes below.
   assign size_done   = remaining_ff[rfd_pkg::SIZE_WIDTH-1] || (remaining_ff == '0);
   assign literal_dec = literal_left_ff - rfd_pkg::LEN_WIDTH'(1);

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      remaining_in    = remaining_ff;
      literal_left_in = literal_left_ff;
      run_len_in      = run_len_ff;
      emit            = 1'b0;
      out_byte_in     = data;
      repeat_len_in   = rfd_pkg::LEN_WIDTH'(1);
      frame_end_in    = 1'b0;
      status_in       = rfd_pkg::STATUS_DATA;

      unique case (phase_ff)
         rfd_pkg::PH_WAIT_CMD: begin
            if (data == command_code_ff) begin
               phase_in        = rfd_pkg::PH_SKIP;
               header_count_in = '0;
            end else begin
               // A wrong command byte reports an error with empty data fields.
               emit          = 1'b1;
               out_byte_in   = '0;
               repeat_len_in = '0;
               status_in     = rfd_pkg::STATUS_BAD_CMD;
            end
         end
         rfd_pkg::PH_SKIP: begin
            if (header_count_ff == rfd_pkg::HDR_LAST) begin
               header_count_in = '0;
               remaining_in    = '0;
               phase_in        = rfd_pkg::PH_SIZE;
            end else begin
               header_count_in = header_count_ff + rfd_pkg::HDR_WIDTH'(1);
            end
         end
         rfd_pkg::PH_SIZE: begin
            // Big-endian 32-bit size, shifted in a byte at a time, kept non-negative.
            remaining_in = {1'b0, remaining_ff[23:0], data};
            if (header_count_ff == rfd_pkg::HDR_LAST) begin
               header_count_in = '0;
               phase_in        = rfd_pkg::PH_COUNT;
            end else begin
               header_count_in = header_count_ff + rfd_pkg::HDR_WIDTH'(1);
            end
         end
         rfd_pkg::PH_COUNT: begin
            if (data > rfd_pkg::RUN_THRESHOLD) begin
               run_len_in   = rfd_pkg::LEN_WIDTH'(rfd_pkg::RUN_BASE - {1'b0, data});
               remaining_in = remaining_ff - $signed({{(rfd_pkg::SIZE_WIDTH
                              - rfd_pkg::LEN_WIDTH){1'b0}}, run_len_in});
               phase_in     = rfd_pkg::PH_RUN_DATA;
            end else begin
               literal_left_in = data + rfd_pkg::LEN_WIDTH'(1);
               remaining_in    = remaining_ff - $signed({{(rfd_pkg::SIZE_WIDTH
                                 - rfd_pkg::LEN_WIDTH){1'b0}}, literal_left_in});
               phase_in        = rfd_pkg::PH_LITERAL;
            end
         end
         rfd_pkg::PH_RUN_DATA: begin
            // The whole run goes out as one result; the receiver expands it.
            emit          = 1'b1;
            repeat_len_in = run_len_ff;
            frame_end_in  = size_done;
            phase_in      = size_done ? rfd_pkg::PH_WAIT_CMD : rfd_pkg::PH_COUNT;
         end
         rfd_pkg::PH_LITERAL: begin
            emit            = 1'b1;
            literal_left_in = literal_dec;
            frame_end_in    = (literal_dec == '0) && size_done;
            if (literal_dec == '0) begin
               phase_in = size_done ? rfd_pkg::PH_WAIT_CMD : rfd_pkg::PH_COUNT;
            end
         end
         default: begin
            phase_in = rfd_pkg::PH_WAIT_CMD;
         end
      endcase
   end

   // The result register fills on a transaction that emits, and empties when
   // its contents are taken without a replacement.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= rfd_pkg::PH_WAIT_CMD;
         header_count_ff <= '0;
         remaining_ff    <= '0;
         literal_left_ff <= '0;
         run_len_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff        <= phase_in;
            header_count_ff <= header_count_in;
            remaining_ff    <= remaining_in;
            literal_left_ff <= literal_left_in;
            run_len_ff      <= run_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_code_ff <= '0;
      end else if (csr_write_enable) begin
         command_code_ff <= csr_write_data;
      end
   end

   // Result payload carries no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_byte_ff   <= out_byte_in;
         repeat_len_ff <= repeat_len_in;
         frame_end_ff  <= frame_end_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_channel.valid      = rsp_valid_ff;
   assign rsp_channel.out_byte   = out_byte_ff;
   assign rsp_channel.repeat_len = repeat_len_ff;
   assign rsp_channel.frame_end  = frame_end_ff;
   assign rsp_channel.status     = status_ff;

`ifndef SYNTHESIS
   // A run data byte always produces a data result in the next cycle.
   a_run_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == rfd_pkg::PH_RUN_DATA) |=>
      (rsp_valid_ff && status_ff == rfd_pkg::STATUS_DATA))
      else $error("run data byte did not produce a data result");

   // Error results carry empty data fields.
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == rfd_pkg::STATUS_BAD_CMD) |->
      (out_byte_ff == '0 && repeat_len_ff == '0 && !frame_end_ff))
      else $error("error result with nonzero data fields");

   // A fresh end-of-frame result leaves the decoder waiting for a command.
   a_end_returns: assert property (@(posedge clock) disable iff (reset)
      accept |=> (!(rsp_valid_ff && frame_end_ff) || phase_ff == rfd_pkg::PH_WAIT_CMD))
      else $error("frame ended but decoder did not return to command wait");

   // The literal counter is only in use inside a literal packet.
   a_literal_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != rfd_pkg::PH_LITERAL) |-> (literal_left_ff == '0))
      else $error("literal counter nonzero outside a literal packet");
`endif

endmodule

`default_nettype wire

FILE: test/rfd_frame_checker.sv
// Checker for the run-length frame decoder: watches both channels and the register port,
// decodes every accepted byte itself and compares each result field by field.
// Depends on rfd_pkg, rfd_req_if and rfd_rsp_if.

module rfd_frame_checker (
   input  logic                           clock,
   input  logic                           reset,
   rfd_req_if                             req_mon,
   rfd_rsp_if                             rsp_mon,
   input  logic                           csr_write_enable,
   input  logic [rfd_pkg::BYTE_WIDTH-1:0] csr_write_data,
   output int                             mismatch_count,
   output int                             outstanding
);
   import rfd_pkg::*;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] out_byte;
      logic [LEN_WIDTH-1:0]  repeat_len;
      logic                  frame_end;
      logic                  status;
   } decoded_type;

   decoded_type                   pending_decodes[$];

   logic [BYTE_WIDTH-1:0]         cmd_code;
   phase_type                     dec_phase;
   logic [HDR_WIDTH-1:0]          hdr_idx;
   logic signed [SIZE_WIDTH-1:0]  bytes_left;
   logic [LEN_WIDTH-1:0]          lit_left;
   logic [LEN_WIDTH-1:0]          run_count;

   // Advances the decoder by one compressed byte and queues the result it yields, if any.
   task automatic decode_byte(input logic [BYTE_WIDTH-1:0] b);
      decoded_type     r;
      logic            done;
      logic [BYTE_WIDTH:0] run_diff;
      r = '0;
      case (dec_phase)
         PH_WAIT_CMD: begin
            if (b == cmd_code) begin
               dec_phase = PH_SKIP;
               hdr_idx = '0;
            end else begin
               r.status = STATUS_BAD_CMD;
               pending_decodes.push_back(r);
            end
         end
         PH_SKIP: begin
            if (hdr_idx == HDR_LAST) begin
               hdr_idx = '0;
               bytes_left = '0;
               dec_phase = PH_SIZE;
            end else begin
               hdr_idx = hdr_idx + 1'b1;
            end
         end
         PH_SIZE: begin
            // Big-endian, kept to 32 unsigned bits.
            bytes_left = {1'b0, bytes_left[23:0], b};
            if (hdr_idx == HDR_LAST) begin
               hdr_idx = '0;
               dec_phase = PH_COUNT;
            end else begin
               hdr_idx = hdr_idx + 1'b1;
            end
         end
         PH_COUNT: begin
            if (b > RUN_THRESHOLD) begin
               run_diff = RUN_BASE - {1'b0, b};
               run_count = run_diff[LEN_WIDTH-1:0];
               bytes_left = bytes_left - $signed({25'd0, run_count});
               dec_phase = PH_RUN_DATA;
            end else begin
               lit_left = b + 8'd1;
               bytes_left = bytes_left - $signed({25'd0, lit_left});
               dec_phase = PH_LITERAL;
            end
         end
         PH_RUN_DATA: begin
            done = (bytes_left <= 33'sd0);
            r.out_byte = b;
            r.repeat_len = run_count;
            r.frame_end = done;
            r.status = STATUS_DATA;
            pending_decodes.push_back(r);
            dec_phase = done ? PH_WAIT_CMD : PH_COUNT;
         end
         PH_LITERAL: begin
            lit_left = lit_left - 8'd1;
            done = (lit_left == 8'd0) && (bytes_left <= 33'sd0);
            r.out_byte = b;
            r.repeat_len = 8'd1;
            r.frame_end = done;
            r.status = STATUS_DATA;
            pending_decodes.push_back(r);
            if (lit_left == 8'd0) begin
               dec_phase = done ? PH_WAIT_CMD : PH_COUNT;
            end
         end
         default: begin
            dec_phase = PH_WAIT_CMD;
         end
      endcase
   endtask

   task automatic check_result();
      decoded_type want;
      if (pending_decodes.size() == 0) begin
         $error("result with none expected: out_byte %0h repeat_len %0d frame_end %0b status %0b",
                rsp_mon.out_byte, rsp_mon.repeat_len, rsp_mon.frame_end, rsp_mon.status);
         mismatch_count++;
      end else begin
         want = pending_decodes.pop_front();
         if (rsp_mon.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_mon.out_byte);
            mismatch_count++;
         end
         if (rsp_mon.repeat_len !== want.repeat_len) begin
            $error("repeat_len: expected %0d, got %0d", want.repeat_len, rsp_mon.repeat_len);
            mismatch_count++;
         end
         if (rsp_mon.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_mon.frame_end);
            mismatch_count++;
         end
         if (rsp_mon.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, rsp_mon.status);
            mismatch_count++;
         end
      end
   endtask

   // Results are checked before the byte of the same edge is decoded, so a result can
   // never be matched against an expectation created at the edge it arrives on.
   always @(posedge clock) begin
      if (reset) begin
         pending_decodes.delete();
         cmd_code = '0;
         dec_phase = PH_WAIT_CMD;
         hdr_idx = '0;
         bytes_left = '0;
         lit_left = '0;
         run_count = '0;
         mismatch_count = 0;
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
         end
         if (req_mon.valid && req_mon.ready) begin
            decode_byte(req_mon.in_byte);
         end
         if (csr_write_enable) begin
            cmd_code = csr_write_data;
         end
         outstanding <= pending_decodes.size();
      end
   end

endmodule

FILE: test/tb_rle_frame_decoder_unit.sv
// Testbench top for the run-length frame decoder: generates compressed frame streams,
// varies back-pressure and the frame command code, and reports the verdict.
// Depends on rfd_pkg, rfd_req_if, rfd_rsp_if, rfd_frame_checker and rle_frame_decoder_unit.

module tb_rle_frame_decoder_unit;
   import rfd_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable;
   logic [BYTE_WIDTH-1:0] csr_write_data;
   int                    mismatch_count;
   int                    outstanding;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int                    send_idle_pct = 31;
   int                    recv_stall_pct = 62;
   int                    bytes_sent = 0;
   logic [BYTE_WIDTH-1:0] current_code = '0;

   rfd_req_if req_bus();
   rfd_rsp_if rsp_bus();

   rle_frame_decoder_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   rfd_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver decides afresh on every edge whether it will take a result, so its
   // stalls land on every phase of the decoder's work.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Offers one byte and returns at the edge where the transaction completes. Valid is
   // only lowered when the sender decides to idle, so back-to-back bytes never see valid
   // dropped and raised again within the same time step.
   task automatic push_byte(input logic [BYTE_WIDTH-1:0] b);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Waits until every expected result has been taken, then lets the pipeline settle,
   // since header and count bytes yield nothing the checker could wait for.
   task automatic wait_drained();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // The command code register is only written while the decoder is quiet.
   task automatic write_code(input logic [BYTE_WIDTH-1:0] code);
      req_bus.valid <= 1'b0;
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= code;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      current_code = code;
   endtask

   // Count bytes lean toward runs and short literals; a long literal packet of up to
   // 128 bytes comes now and then.
   function automatic logic [BYTE_WIDTH-1:0] pick_count();
      int r;
      r = $urandom_range(0, 15);
      if (r < 7) begin
         return 8'h80 + 8'($urandom_range(0, 127));
      end else if (r < 15) begin
         return 8'($urandom_range(0, 7));
      end else begin
         return 8'($urandom_range(0, 127));
      end
   endfunction

   // Unpacked sizes are mostly small so that many frames fit in the run.
   function automatic logic [31:0] pick_size();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 32'd0;
      end else if (r < 7) begin
         return 32'($urandom_range(1, 24));
      end else begin
         return 32'($urandom_range(25, 300));
      end
   endfunction

   // Sends one well-formed frame with random content. The generator tracks the remaining
   // size only to know where the frame stops; a packet cap of zero means no cap.
   task automatic send_frame(input logic [31:0] size, input int packet_cap);
      logic signed [SIZE_WIDTH-1:0] left;
      logic [BYTE_WIDTH-1:0]        count;
      int                           plen;
      int                           packets;
      left = {1'b0, size};
      packets = 0;
      push_byte(current_code);
      repeat (4) push_byte(8'($urandom_range(0, 255)));
      for (int i = 3; i >= 0; i--) begin
         push_byte(size[8*i +: 8]);
      end
      // At least one packet is always sent, which is what a size of zero requires.
      do begin
         count = pick_count();
         push_byte(count);
         if (count > RUN_THRESHOLD) begin
            plen = 257 - int'(count);
            push_byte(8'($urandom_range(0, 255)));
         end else begin
            plen = int'(count) + 1;
            repeat (plen) push_byte(8'($urandom_range(0, 255)));
         end
         left = left - plen;
         packets++;
      end while (left > 0 && (packet_cap == 0 || packets < packet_cap));
   endtask

   // Mostly whole frames; the rest are stray bytes that are not the command code and
   // so must each be flagged as a bad command.
   task automatic run_block(input int byte_goal);
      int                    start;
      logic [BYTE_WIDTH-1:0] stray;
      start = bytes_sent;
      while (bytes_sent - start < byte_goal) begin
         if ($urandom_range(0, 9) < 2) begin
            stray = 8'($urandom_range(0, 255));
            if (stray == current_code) begin
               stray = ~stray;
            end
            push_byte(stray);
         end else begin
            send_frame(pick_size(), 0);
         end
      end
   endtask

   initial begin
      // Opening sequence, decoded with the reset command code of zero: a bad command
      // byte, a frame of size zero whose single literal packet is still decoded, and a
      // frame whose one 129-byte run brings the size exactly to zero.
      logic [BYTE_WIDTH-1:0] opening [0:22];
      logic [BYTE_WIDTH-1:0] block_codes [0:5];
      opening = '{8'hFF,
                  8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h81, 8'h80, 8'hA5};
      block_codes = '{8'hFF, 8'($urandom_range(0, 255)), 8'h00,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h01};

      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) begin
         push_byte(opening[i]);
      end

      // Six blocks of random traffic, each under its own command code. The first pair
      // runs with a lazy receiver, the second with a lazy sender, the last with neither.
      for (int blk = 0; blk < 6; blk++) begin
         if (blk == 2) begin
            send_idle_pct = 62;
            recv_stall_pct = 31;
         end else if (blk == 4) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         write_code(block_codes[blk]);
         run_block(80);
      end

      // A size with the top bit set must count as a large unsigned value, so a few
      // packets never finish this frame.
      send_frame(32'h8000_0000 | 32'($urandom), 6);

      req_bus.valid <= 1'b0;
      wait_drained();

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Far beyond the slowest correct run of this stimulus.
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/rfd_pkg.sv
hw/rtl/rfd_req_if.sv
hw/rtl/rfd_rsp_if.sv
hw/rtl/rle_frame_decoder_unit.sv
test/rfd_frame_checker.sv
test/tb_rle_frame_decoder_unit.sv
